// ===== rtl/bfhp_pkg.sv =====
// shared types, constants and a lookup function for the bit file header parser
package bfhp_pkg;

    localparam int unsigned PHASE_W    = 5;
    localparam int unsigned POS_W      = 16;
    localparam int unsigned SLEN_W     = 16;
    localparam int unsigned ACC_W      = 32;
    localparam int unsigned KIND_W     = 3;
    localparam int unsigned PREFIX_LEN = 13;
    localparam int unsigned PLEN_BYTES = 4;

    localparam logic [PHASE_W-1:0] PH_PREFIX  = 5'd0;
    localparam logic [PHASE_W-1:0] PH_STR_LO  = 5'd1;
    localparam logic [PHASE_W-1:0] PH_STR_HI  = 5'd16;
    localparam logic [PHASE_W-1:0] PH_E_MARK  = 5'd17;
    localparam logic [PHASE_W-1:0] PH_PLEN    = 5'd18;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 5'd19;

    localparam logic [1:0] SUB_MARKER = 2'd0;
    localparam logic [1:0] SUB_LEN_HI = 2'd1;
    localparam logic [1:0] SUB_LEN_LO = 2'd2;
    localparam logic [1:0] SUB_BODY   = 2'd3;

    localparam logic [KIND_W-1:0] KIND_FIXED   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NAME    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DEVICE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DATE    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TIME    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_TERM    = 3'd5;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 3'd6;

    localparam logic [7:0] MARK_A     = 8'h61;
    localparam logic [7:0] MARK_E     = 8'h65;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [7:0]        char_out;
        logic              header_ok;
        logic              header_done;
        logic [ACC_W-1:0]  stream_length;
    } bfhp_result_t;

    function automatic logic [7:0] prefix_byte(input logic [3:0] idx);
        logic [7:0] val;
        begin
            case (idx)
                4'd0:    val = 8'h00;
                4'd1:    val = 8'h09;
                4'd2:    val = 8'h0f;
                4'd3:    val = 8'hf0;
                4'd4:    val = 8'h0f;
                4'd5:    val = 8'hf0;
                4'd6:    val = 8'h0f;
                4'd7:    val = 8'hf0;
                4'd8:    val = 8'h0f;
                4'd9:    val = 8'hf0;
                4'd10:   val = 8'h00;
                4'd11:   val = 8'h00;
                4'd12:   val = 8'h01;
                default: val = 8'h00;
            endcase
            return val;
        end
    endfunction

endpackage

// ===== rtl/bfhp_if.sv =====
// request channel interfaces for raw bytes in and classified bytes out
interface bfhp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       new_file;

    modport source (output valid, output data_byte, output new_file, input ready);
    modport sink   (input valid, input data_byte, input new_file, output ready);
endinterface

interface bfhp_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  char_out;
    logic        header_ok;
    logic        header_done;
    logic [31:0] stream_length;

    modport source (output valid, output kind, output char_out, output header_ok,
                    output header_done, output stream_length, input ready);
    modport sink   (input valid, input kind, input char_out, input header_ok,
                    input header_done, input stream_length, output ready);
endinterface

// ===== rtl/bit_file_header_parser.sv =====
// an accepted byte is held in the input register, then its result is registered in the result register
// throughput: one byte per cycle while the output is not backpressured, set by the single parser state update per byte
// on output backpressure the result register holds, and the input register holds once it is full
// reset: parser returns to the start of the magic prefix with the ok flag set,
// both pipeline registers empty
module bit_file_header_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    bfhp_byte_if.sink            byte_in,
    bfhp_result_if.source        result_out
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_new_reg;
    logic                   out_valid_reg;
    bfhp_pkg::bfhp_result_t out_res_reg;
    bfhp_pkg::bfhp_result_t step_res;
    logic                   advance;
    logic                   in_take;

    assign advance = in_valid_reg && (!out_valid_reg || result_out.ready);
    assign byte_in.ready = !in_valid_reg || !out_valid_reg || result_out.ready;
    assign in_take = byte_in.valid && byte_in.ready;

    bfhp_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .data_byte (in_byte_reg),
        .new_file  (in_new_reg),
        .result    (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= byte_in.data_byte;
            in_new_reg  <= byte_in.new_file;
        end
        if (advance)
        begin
            out_res_reg <= step_res;
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.kind          = out_res_reg.kind;
    assign result_out.char_out      = out_res_reg.char_out;
    assign result_out.header_ok     = out_res_reg.header_ok;
    assign result_out.header_done   = out_res_reg.header_done;
    assign result_out.stream_length = out_res_reg.stream_length;

endmodule

// ===== rtl/bfhp_step.sv =====
// parser state registers and the per-byte classification logic
module bfhp_step (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic [7:0]            data_byte,
    input  logic                  new_file,
    output bfhp_pkg::bfhp_result_t result
);

    logic [bfhp_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [bfhp_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [bfhp_pkg::SLEN_W-1:0]  slen_reg, slen_next;
    logic                         ok_reg, ok_next;
    logic [bfhp_pkg::ACC_W-1:0]   acc_reg, acc_next;

    logic [bfhp_pkg::PHASE_W-1:0] cur_phase;
    logic [bfhp_pkg::POS_W-1:0]   cur_pos;
    logic [bfhp_pkg::SLEN_W-1:0]  cur_slen;
    logic                         cur_ok;
    logic [bfhp_pkg::ACC_W-1:0]   cur_acc;
    logic [bfhp_pkg::PHASE_W-1:0] str_idx;
    logic [1:0]                   str_num;
    logic [1:0]                   str_sub;
    logic [bfhp_pkg::POS_W:0]     pos_inc;

    always_comb
    begin
        // restart drops all state before this byte is looked at
        cur_phase = new_file ? bfhp_pkg::PH_PREFIX : phase_reg;
        cur_pos   = new_file ? '0 : pos_reg;
        cur_slen  = new_file ? '0 : slen_reg;
        cur_ok    = new_file ? 1'b1 : ok_reg;
        cur_acc   = new_file ? '0 : acc_reg;

        str_idx = cur_phase - bfhp_pkg::PH_STR_LO;
        str_num = str_idx[3:2];
        str_sub = str_idx[1:0];
        pos_inc = {1'b0, cur_pos} + 17'd1;

        phase_next = cur_phase;
        pos_next   = cur_pos;
        slen_next  = cur_slen;
        ok_next    = cur_ok;
        acc_next   = cur_acc;

        result.kind        = bfhp_pkg::KIND_FIXED;
        result.char_out    = data_byte;
        result.header_done = 1'b0;

        if (cur_phase == bfhp_pkg::PH_PREFIX)
        begin
            if (data_byte != bfhp_pkg::prefix_byte(cur_pos[3:0]))
            begin
                ok_next = 1'b0;
            end
            if (pos_inc >= 17'(bfhp_pkg::PREFIX_LEN))
            begin
                pos_next   = '0;
                phase_next = bfhp_pkg::PH_STR_LO;
            end
            else
            begin
                pos_next = pos_inc[bfhp_pkg::POS_W-1:0];
            end
        end
        else if (cur_phase >= bfhp_pkg::PH_STR_LO && cur_phase <= bfhp_pkg::PH_STR_HI)
        begin
            case (str_sub)
                bfhp_pkg::SUB_MARKER:
                begin
                    if (data_byte != bfhp_pkg::MARK_A + {6'd0, str_num})
                    begin
                        ok_next = 1'b0;
                    end
                    phase_next = cur_phase + 5'd1;
                end
                bfhp_pkg::SUB_LEN_HI:
                begin
                    slen_next  = {data_byte, 8'h00};
                    phase_next = cur_phase + 5'd1;
                end
                bfhp_pkg::SUB_LEN_LO:
                begin
                    slen_next  = {cur_slen[15:8], data_byte};
                    pos_next   = '0;
                    // empty string skips its body
                    phase_next = ({cur_slen[15:8], data_byte} == 16'd0) ?
                                 cur_phase + 5'd2 : cur_phase + 5'd1;
                end
                default:
                begin
                    if (pos_inc >= {1'b0, cur_slen})
                    begin
                        result.kind = bfhp_pkg::KIND_TERM;
                        pos_next    = '0;
                        phase_next  = cur_phase + 5'd1;
                    end
                    else
                    begin
                        result.kind = bfhp_pkg::KIND_NAME + {1'b0, str_num};
                        if (str_num[1] && data_byte == bfhp_pkg::CHAR_SPACE)
                        begin
                            result.char_out = bfhp_pkg::CHAR_ZERO;
                        end
                        pos_next = pos_inc[bfhp_pkg::POS_W-1:0];
                    end
                end
            endcase
        end
        else if (cur_phase == bfhp_pkg::PH_E_MARK)
        begin
            if (data_byte != bfhp_pkg::MARK_E)
            begin
                ok_next = 1'b0;
            end
            pos_next   = '0;
            phase_next = bfhp_pkg::PH_PLEN;
        end
        else if (cur_phase == bfhp_pkg::PH_PLEN)
        begin
            acc_next = {cur_acc[23:0], data_byte};
            if (pos_inc >= 17'(bfhp_pkg::PLEN_BYTES))
            begin
                result.header_done = 1'b1;
                pos_next           = '0;
                phase_next         = bfhp_pkg::PH_PAYLOAD;
            end
            else
            begin
                pos_next = pos_inc[bfhp_pkg::POS_W-1:0];
            end
        end
        else
        begin
            result.kind = bfhp_pkg::KIND_PAYLOAD;
            phase_next  = bfhp_pkg::PH_PAYLOAD;
        end

        result.header_ok     = ok_next;
        result.stream_length = acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= bfhp_pkg::PH_PREFIX;
            pos_reg   <= '0;
            slen_reg  <= '0;
            ok_reg    <= 1'b1;
            acc_reg   <= '0;
        end
        else if (en)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            slen_reg  <= slen_next;
            ok_reg    <= ok_next;
            acc_reg   <= acc_next;
        end
    end

endmodule
